>>> rtl/idqp_pkg.sv
// ----------------------------------------------------------------------------
// idqp_pkg: shared types and constants of the dotted-quad parser
// character classes, the token passed from front to back, queue sizes
// ----------------------------------------------------------------------------
package idqp_pkg;

  localparam int unsigned TokDepth = 2;
  localparam int unsigned ResDepth = 2;
  localparam int unsigned TokPtrW  = $clog2(TokDepth);
  localparam int unsigned TokCntW  = $clog2(TokDepth + 1);
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  localparam logic [7:0] CharTerm  = 8'h00;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] OctetMax  = 8'd255;
  localparam logic [1:0] DotsNeeded = 2'd3;

  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_DOT,
    CLS_TERM,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
  } tok_t;

  // head of the token queue as seen by the back end
  typedef struct packed {
    logic valid;
    tok_t tok;
  } tok_link_t;

endpackage

>>> rtl/idqp_front.sv
// ----------------------------------------------------------------------------
// idqp_front: character classifier and token queue
// classifies each accepted character and holds it in a short queue
// ----------------------------------------------------------------------------
module idqp_front import idqp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch_i,
  output tok_link_t  link_o,
  input  logic       tok_pop_i
);

  tok_t               mem_q [TokDepth];
  logic [TokPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [TokPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [TokCntW-1:0] cnt_q, cnt_d;
  logic               wr_en, rd_en;
  tok_t               tok_new;

  // classify
  always_comb begin
    tok_new.digit = ch_i[3:0];
    if (ch_i == CharTerm) begin
      tok_new.cls = CLS_TERM;
    end else if (ch_i == CharDot) begin
      tok_new.cls = CLS_DOT;
    end else if (ch_i >= CharZero && ch_i <= CharNine) begin
      tok_new.cls = CLS_DIGIT;
    end else begin
      tok_new.cls = CLS_OTHER;
    end
  end

  assign full  = (cnt_q == TokCntW'(TokDepth));
  assign wr_en = push && !full;
  assign rd_en = tok_pop_i && (cnt_q != '0);

  assign link_o.valid = (cnt_q != '0);
  assign link_o.tok   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == TokPtrW'(TokDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == TokPtrW'(TokDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= tok_new;
    end
  end

  // queue never overfills
  a_tok_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= TokCntW'(TokDepth))
    else $error("token queue count out of range");

  // a beat taken with nothing popped grows the queue by one
  a_tok_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && !rd_en |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("token queue count did not grow");

endmodule

>>> rtl/idqp_back.sv
// ----------------------------------------------------------------------------
// idqp_back: parse engine and result queue
// applies each token to the address state and queues one result per string
// ----------------------------------------------------------------------------
module idqp_back import idqp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tok_link_t   link_i,
  output logic        tok_pop_o,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] address_o,
  output logic        ok_o
);

  logic [31:0] acc_q, acc_d;
  logic [1:0]  dots_q, dots_d;
  logic        at_start_q, at_start_d;
  logic        failed_q, failed_d;

  logic [31:0]        res_addr_q [ResDepth];
  logic               res_ok_q   [ResDepth];
  logic [ResPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic               res_full, res_wr, res_rd;
  logic               take, good;
  logic [7:0]         cur;
  logic [11:0]        next_val;

  assign res_full  = (cnt_q == ResCntW'(ResDepth));
  assign take      = link_i.valid && !res_full;
  assign tok_pop_o = take;
  assign res_wr    = take && (link_i.tok.cls == CLS_TERM);
  assign res_rd    = pop && !empty;

  assign cur      = acc_q[7:0];
  // cur * 10 + digit
  assign next_val = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0} + {8'd0, link_i.tok.digit};
  assign good     = !failed_q && (dots_q == DotsNeeded) && !at_start_q;

  always_comb begin
    acc_d      = acc_q;
    dots_d     = dots_q;
    at_start_d = at_start_q;
    failed_d   = failed_q;
    if (take) begin
      if (link_i.tok.cls == CLS_TERM) begin
        acc_d      = '0;
        dots_d     = '0;
        at_start_d = 1'b1;
        failed_d   = 1'b0;
      end else if (!failed_q) begin
        case (link_i.tok.cls)
          CLS_DIGIT: begin
            if (cur == 8'd0 && !at_start_q) begin
              failed_d = 1'b1;
            end else if (next_val > {4'd0, OctetMax}) begin
              failed_d = 1'b1;
            end else begin
              acc_d      = {acc_q[31:8], next_val[7:0]};
              at_start_d = 1'b0;
            end
          end
          CLS_DOT: begin
            if (at_start_q || dots_q == DotsNeeded) begin
              failed_d = 1'b1;
            end else begin
              dots_d     = dots_q + 1'b1;
              acc_d      = {acc_q[23:0], 8'd0};
              at_start_d = 1'b1;
            end
          end
          default: begin
            failed_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (res_wr && !res_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!res_wr && res_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      dots_q     <= '0;
      at_start_q <= 1'b1;
      failed_q   <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      acc_q      <= acc_d;
      dots_q     <= dots_d;
      at_start_q <= at_start_d;
      failed_q   <= failed_d;
      cnt_q      <= cnt_d;
      if (res_wr) begin
        wr_ptr_q <= (wr_ptr_q == ResPtrW'(ResDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (res_rd) begin
        rd_ptr_q <= (rd_ptr_q == ResPtrW'(ResDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      res_addr_q[wr_ptr_q] <= good ? acc_q : 32'd0;
      res_ok_q[wr_ptr_q]   <= good;
    end
  end

  assign empty     = (cnt_q == '0);
  assign address_o = res_addr_q[rd_ptr_q];
  assign ok_o      = res_ok_q[rd_ptr_q];

  // terminator brings the parse state back to its reset values
  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr |=> acc_q == '0 && dots_q == '0 && at_start_q && !failed_q)
    else $error("parse state not cleared after terminator");

  // a nonzero value in the open octet means the octet has started
  a_octet_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    at_start_q |-> acc_q[7:0] == 8'd0)
    else $error("octet marked open but holds a value");

endmodule

>>> rtl/ipv4_dotted_quad_parser.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser: strict dotted-decimal ipv4 address parser
// one character per beat, one address result per zero-terminated string
// ----------------------------------------------------------------------------
// feed the address text one character per push beat, ending with a zero
// character; each terminator yields one result beat with the address (first
// octet in bits 31:24) and ok set, or address 0 with ok clear when the text
// is not a strict dotted quad (octet above 255, leading zero, empty octet,
// wrong dot count, stray character). characters after a failure are dropped
// until the terminator, which also returns the parser to its reset state.
// the block takes one character every cycle while full is low: the front
// classifies and queues characters, the back applies one token per cycle
// unless the result queue is full (a 10x multiply-add and compare on the
// open octet). a terminator's result passes through the token queue and then
// the result queue before it can be popped, and both queues are two beats
// deep so either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser import idqp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character input, queue style
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch_i,
  // result output, queue style
  output logic        empty,
  input  logic        pop,
  output logic [31:0] address_o,
  output logic        ok_o
);

  tok_link_t link;
  logic      tok_pop;

  // front: classify characters into tokens, buffer them
  idqp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .ch_i      (ch_i),
    .link_o    (link),
    .tok_pop_i (tok_pop)
  );

  // back: run the octet and dot bookkeeping, queue results
  idqp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .link_i    (link),
    .tok_pop_o (tok_pop),
    .empty     (empty),
    .pop       (pop),
    .address_o (address_o),
    .ok_o      (ok_o)
  );

endmodule

>>> test/ipv4_dotted_quad_parser_test.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser_test: self-checking bench for the dotted-quad parser
// feeds zero-terminated address strings one character per beat and checks
// every address/ok result beat against an in-bench parser model
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser_test import idqp_pkg::*;;

  localparam int unsigned Radix       = 10;
  localparam int unsigned LongHold    = 400;   // receiver hold-off after reset
  localparam int unsigned DrainCycles = 20;    // settle time after last result
  localparam int unsigned RandomChars = 1950;  // size of the random part
  localparam int unsigned MaxShown    = 10;    // mismatches printed in full

  // one result beat as the block presents it
  typedef struct packed {
    logic [31:0] address;
    logic        ok;
  } quad_result_t;

  // parser model plus the queue of addresses still owed by the block
  class quad_scoreboard;
    logic [31:0]  acc;      // closed octets shifted up, open octet in 7:0
    logic [1:0]   dots;
    bit           fresh;    // no digit yet in the open octet
    bit           bad;      // string already known to be invalid
    quad_result_t want_q[$];
    int           mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      acc   = '0;
      dots  = '0;
      fresh = 1'b1;
      bad   = 1'b0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function void note_char(logic [7:0] c);
      int unsigned v;
      bit          good;
      if (c == CharTerm) begin
        good = !bad && dots == DotsNeeded && !fresh;
        want_q.push_back('{good ? acc : 32'h0, good});
        restart();
      end else if (!bad) begin
        if (c >= CharZero && c <= CharNine) begin
          v = int'(acc[7:0]) * Radix + int'(c - CharZero);
          if ((acc[7:0] == 8'h00 && !fresh) || v > int'(OctetMax)) begin
            bad = 1'b1;
          end else begin
            acc[7:0] = 8'(v);
            fresh    = 1'b0;
          end
        end else if (c == CharDot) begin
          if (fresh || dots == DotsNeeded) begin
            bad = 1'b1;
          end else begin
            dots  = dots + 2'd1;
            acc   = acc << 8;
            fresh = 1'b1;
          end
        end else begin
          bad = 1'b1;
        end
      end
    endfunction

    function void check_result(logic [31:0] a, logic o);
      quad_result_t want;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("unexpected result beat: address %h ok %b", a, o);
        return;
      end
      want = want_q.pop_front();
      if (a !== want.address || o !== want.ok) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("result mismatch: expected address %h ok %b, got address %h ok %b",
                   want.address, want.ok, a, o);
      end
    endfunction
  endclass

  // dut hookup, every input known from time zero
  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push   = 1'b0;
  logic        full;
  logic [7:0]  ch_i   = '0;
  logic        empty;
  logic        pop    = 1'b0;
  logic [31:0] address_o;
  logic        ok_o;

  ipv4_dotted_quad_parser u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .ch_i      (ch_i),
    .empty     (empty),
    .pop       (pop),
    .address_o (address_o),
    .ok_o      (ok_o)
  );

  quad_scoreboard sb;
  logic [7:0]     line_q[$];      // characters of the string being sent
  int             burst_left = 0; // beats left in the current sender burst

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  // both handshakes sampled on the clock edge, before any driver update lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_result(address_o, ok_o);
      if (push && !full) sb.note_char(ch_i);
    end
  end

  // one character beat; bursts of random length with random gaps between,
  // and now and then a gap of zero so long runs go through unbroken
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        ch_i <= 8'($urandom);   // junk on the data lines while idle
        repeat (gap) @(posedge clk_i);
      end
    end
    push <= 1'b1;
    ch_i <= c;
    do @(posedge clk_i); while (full);
    burst_left--;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
  endtask

  // directed string plus terminator
  task automatic send_text(input string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    line_q.push_back(CharTerm);
    send_line();
  endtask

  // sender stops and waits until every owed result has come out
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // decimal text of v without leading zeros; v up to 999
  function automatic void add_octet(int v);
    if (v >= 100) line_q.push_back(8'(CharZero + v / 100));
    if (v >= 10)  line_q.push_back(8'(CharZero + (v / 10) % 10));
    line_q.push_back(8'(CharZero + v % 10));
  endfunction

  // mostly well-formed quads with random octets, the rest broken on purpose
  function automatic void build_line();
    int flaw;
    int oct_bad;
    int pos;
    int v;
    line_q.delete();
    flaw    = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 7) : -1;
    oct_bad = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      if (k > 0) line_q.push_back(CharDot);
      case ($urandom_range(0, 3))
        0:       v = 0;
        1:       v = int'(OctetMax);
        default: v = $urandom_range(0, 255);
      endcase
      if (flaw == 4 && k == oct_bad) v = $urandom_range(256, 999);
      add_octet(v);
    end
    case (flaw)
      0: begin  // stray byte somewhere
        pos = $urandom_range(0, line_q.size() - 1);
        line_q[pos] = 8'($urandom_range(1, 255));
      end
      1: line_q.insert($urandom_range(0, line_q.size()), CharDot);
      2: line_q.delete($urandom_range(0, line_q.size() - 1));
      3: line_q.insert(0, CharZero);  // leading zero on the first octet
      5: begin  // one octet too many
        line_q.push_back(CharDot);
        line_q.push_back(8'(CharZero + $urandom_range(0, 9)));
      end
      6: begin  // cut short
        pos = $urandom_range(0, line_q.size() - 1);
        while (line_q.size() > pos) void'(line_q.pop_back());
      end
      7: begin  // pure noise
        line_q.delete();
        repeat ($urandom_range(0, 12)) line_q.push_back(8'($urandom_range(1, 255)));
      end
      default: ;
    endcase
    line_q.push_back(CharTerm);
  endfunction

  // receiver: a long hold right after reset so both queues fill and full
  // rises, then random runs of pop with short stalls and the odd long hold
  initial begin
    int run;
    int stall;
    do @(posedge clk_i); while (!rst_ni);
    repeat (LongHold) @(posedge clk_i);
    forever begin
      run = $urandom_range(1, 24);
      pop <= 1'b1;
      repeat (run) @(posedge clk_i);
      if ($urandom_range(0, 39) == 0)
        stall = $urandom_range(40, 150);
      else if ($urandom_range(0, 2) == 0)
        stall = 0;
      else
        stall = $urandom_range(1, 6);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // stimulus
  initial begin
    int  sent;
    bit  paused;
    sb     = new();
    sent   = 0;
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings, sent while the receiver is still holding off
    send_text("255.0.9.10");  // valid, octet extremes
    send_text("");            // empty string
    send_text(".5");          // dot at start
    send_text("01");          // leading zero
    send_text("256");         // octet above 255
    send_text("9..");         // two dots in a row
    send_text("0.0.0.0.");    // fourth dot
    send_text("1.2.3.");      // trailing dot
    send_text("1.2");         // too few dots
    send_text("/3");          // stray character just below the digits
    line_q = '{8'hFF, CharNine, CharTerm};  // all-ones byte, rest ignored
    send_line();
    drain();

    // random strings; halfway the sender stops until everything is out
    while (sent < RandomChars) begin
      build_line();
      sent += line_q.size();
      send_line();
      if (!paused && sent >= RandomChars / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
